### sv/hdlc_rx_pkg.sv
// ----------------------------------------------------------------------------
// HDLC receiver package
// Shared constants, status codes and the token type that travels from the
// destuffing front end to the frame checker.
// ----------------------------------------------------------------------------
package hdlc_rx_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 11;

  localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
  localparam logic [BYTE_W-1:0] ESC_XOR   = 8'h20;

  localparam logic [LEN_W-1:0] INDEX_MAX = 11'd2047;

  // Result kinds.
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Frame status codes.
  localparam logic [2:0] STAT_SUP_OK   = 3'd0;
  localparam logic [2:0] STAT_INFO_OK  = 3'd1;
  localparam logic [2:0] STAT_HDR_ERR  = 3'd2;
  localparam logic [2:0] STAT_PAY_ERR  = 3'd3;
  localparam logic [2:0] STAT_FMT_ERR  = 3'd4;

  // Token queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic              is_close;  // closing flag rather than a data byte
    logic              esc;       // closing flag came right after an escape
    logic [BYTE_W-1:0] data;      // unescaped byte
  } token_t;

endpackage

### sv/hdlc_rx_front.sv
// ----------------------------------------------------------------------------
// HDLC receiver front end
// Hunts for the opening flag, removes escapes and turns each line byte into
// at most one token: an unescaped data byte or a closing flag.
// ----------------------------------------------------------------------------
module hdlc_rx_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                rx_byte,
  input  logic                      q_full,
  output logic                      push,
  output hdlc_rx_pkg::token_t       push_tok
);
  import hdlc_rx_pkg::*;

  logic in_frame;
  logic esc_pending;
  logic any_seen;
  logic accept;
  logic is_flag;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_flag  = (rx_byte == FLAG_BYTE);

  always_comb begin
    push              = 1'b0;
    push_tok.is_close = 1'b0;
    push_tok.esc      = esc_pending;
    push_tok.data     = esc_pending ? (rx_byte ^ ESC_XOR) : rx_byte;
    if (accept && in_frame) begin
      if (is_flag) begin
        // Back-to-back flags with nothing between them are dropped here.
        push_tok.is_close = 1'b1;
        push              = any_seen || esc_pending;
      end else if (!(rx_byte == ESC_BYTE && !esc_pending)) begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      esc_pending <= 1'b0;
      any_seen    <= 1'b0;
    end else if (accept) begin
      if (is_flag) begin
        in_frame    <= 1'b1;
        esc_pending <= 1'b0;
        any_seen    <= 1'b0;
      end else if (in_frame) begin
        if (rx_byte == ESC_BYTE && !esc_pending) begin
          esc_pending <= 1'b1;
        end else begin
          esc_pending <= 1'b0;
          any_seen    <= 1'b1;
        end
      end
    end
  end

endmodule

### sv/hdlc_rx_queue.sv
// ----------------------------------------------------------------------------
// HDLC receiver token queue
// Short FIFO that decouples the destuffing front end from the frame checker.
// ----------------------------------------------------------------------------
module hdlc_rx_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  hdlc_rx_pkg::token_t       push_tok,
  output logic                      full,
  output logic                      q_valid,
  output hdlc_rx_pkg::token_t       q_tok,
  input  logic                      pop
);
  import hdlc_rx_pkg::*;

  token_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_tok   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/hdlc_rx_back.sv
// ----------------------------------------------------------------------------
// HDLC receiver back end
// Tracks the frame header and block checks, holds payload one byte back and
// drives the registered result port.
// ----------------------------------------------------------------------------
module hdlc_rx_back #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [10:0]               cfg_write_data,
  input  logic                      q_valid,
  input  hdlc_rx_pkg::token_t       q_tok,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_kind,
  output logic [7:0]                data_byte,
  output logic [2:0]                frame_status,
  output logic [7:0]                frame_addr,
  output logic [7:0]                frame_ctrl,
  output logic [10:0]               payload_len
);
  import hdlc_rx_pkg::*;

  localparam logic [LEN_W-1:0] LIM_MAX = LEN_W'(MAX_PAYLOAD);

  logic [LEN_W-1:0]  limit;
  logic [LEN_W-1:0]  byte_index, byte_index_next;
  logic [BYTE_W-1:0] hdr_addr, hdr_addr_next;
  logic [BYTE_W-1:0] hdr_ctrl, hdr_ctrl_next;
  logic              header_good, header_good_next;
  logic [BYTE_W-1:0] held_byte, held_byte_next;
  logic [BYTE_W-1:0] running_xor, running_xor_next;
  logic              overflow_seen, overflow_seen_next;
  logic              ovf_now;

  logic              res_valid;
  logic              res_kind;
  logic [BYTE_W-1:0] res_data;
  logic [2:0]        res_status;
  logic [BYTE_W-1:0] res_addr;
  logic [BYTE_W-1:0] res_ctrl;
  logic [LEN_W-1:0]  res_len;

  // A token is taken whenever the output register is empty or being drained.
  assign pop = q_valid && (!out_valid || !out_stall);

  // The limit is clamped once, when written.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIM_MAX;
    end else if (cfg_write_en) begin
      if (cfg_write_data == '0) begin
        limit <= LEN_W'(1);
      end else if (cfg_write_data > LIM_MAX) begin
        limit <= LIM_MAX;
      end else begin
        limit <= cfg_write_data;
      end
    end
  end

  always_comb begin
    byte_index_next    = byte_index;
    hdr_addr_next      = hdr_addr;
    hdr_ctrl_next      = hdr_ctrl;
    header_good_next   = header_good;
    held_byte_next     = held_byte;
    running_xor_next   = running_xor;
    overflow_seen_next = overflow_seen;
    ovf_now            = overflow_seen;
    res_valid          = 1'b0;
    res_kind           = KIND_DATA;
    res_data           = '0;
    res_status         = STAT_SUP_OK;
    res_addr           = '0;
    res_ctrl           = '0;
    res_len            = '0;
    if (pop) begin
      if (q_tok.is_close) begin
        res_valid = 1'b1;
        res_kind  = KIND_STATUS;
        res_addr  = hdr_addr;
        res_ctrl  = hdr_ctrl;
        if (q_tok.esc || overflow_seen || byte_index < LEN_W'(3) ||
            byte_index == LEN_W'(4)) begin
          res_status = STAT_FMT_ERR;
        end else if (!header_good) begin
          res_status = STAT_HDR_ERR;
        end else if (byte_index == LEN_W'(3)) begin
          res_status = STAT_SUP_OK;
        end else begin
          res_len    = byte_index - LEN_W'(4);
          res_status = (running_xor == '0) ? STAT_INFO_OK : STAT_PAY_ERR;
        end
        byte_index_next    = '0;
        hdr_addr_next      = '0;
        hdr_ctrl_next      = '0;
        header_good_next   = 1'b0;
        held_byte_next     = '0;
        running_xor_next   = '0;
        overflow_seen_next = 1'b0;
      end else if (byte_index == LEN_W'(0)) begin
        hdr_addr_next   = q_tok.data;
        byte_index_next = byte_index + 1'b1;
      end else if (byte_index == LEN_W'(1)) begin
        hdr_ctrl_next   = q_tok.data;
        byte_index_next = byte_index + 1'b1;
      end else if (byte_index == LEN_W'(2)) begin
        header_good_next = (q_tok.data == (hdr_addr ^ hdr_ctrl));
        byte_index_next  = byte_index + 1'b1;
      end else begin
        running_xor_next = running_xor ^ q_tok.data;
        if (byte_index >= LEN_W'(4)) begin
          // The held byte becomes payload byte number byte_index - 3.
          ovf_now            = overflow_seen || ((byte_index - LEN_W'(3)) > limit);
          overflow_seen_next = ovf_now;
          if (header_good && !ovf_now) begin
            res_valid = 1'b1;
            res_data  = held_byte;
          end
        end
        held_byte_next = q_tok.data;
        if (byte_index != INDEX_MAX) begin
          byte_index_next = byte_index + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      hdr_addr      <= '0;
      hdr_ctrl      <= '0;
      header_good   <= 1'b0;
      held_byte     <= '0;
      running_xor   <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      byte_index    <= byte_index_next;
      hdr_addr      <= hdr_addr_next;
      hdr_ctrl      <= hdr_ctrl_next;
      header_good   <= header_good_next;
      held_byte     <= held_byte_next;
      running_xor   <= running_xor_next;
      overflow_seen <= overflow_seen_next;
      if (pop) begin
        out_valid <= res_valid;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      out_kind     <= res_kind;
      data_byte    <= res_data;
      frame_status <= res_status;
      frame_addr   <= res_addr;
      frame_ctrl   <= res_ctrl;
      payload_len  <= res_len;
    end
  end

endmodule

### sv/hdlc_frame_receiver.sv
// ----------------------------------------------------------------------------
// HDLC frame receiver
// Byte-stuffed frame deframer with XOR header and payload block checks.
//
//   Channel   Direction  Handshake            Payload
//   input     in         in_valid / in_stall  rx_byte
//   result    out        out_valid/out_stall  out_kind, data_byte, frame_status,
//                                             frame_addr, frame_ctrl, payload_len
//   config    in         cfg_write_en         cfg_write_data (max_payload_len)
//
// One line byte is taken per cycle while in_stall is low. A token is queued
// when its byte is transferred, waits in the token queue and, when popped,
// loads the result register, from which the result is transferred once
// out_stall is low. The four-entry token queue absorbs output stalls;
// in_stall rises only when it is full. Reset clears the control state and
// sets the payload limit to MAX_PAYLOAD.
// ----------------------------------------------------------------------------
module hdlc_frame_receiver #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_write_en,
  input  logic [10:0] cfg_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  data_byte,
  output logic [2:0]  frame_status,
  output logic [7:0]  frame_addr,
  output logic [7:0]  frame_ctrl,
  output logic [10:0] payload_len
);
  import hdlc_rx_pkg::*;

  logic   push;
  token_t push_tok;
  logic   q_full;
  logic   q_valid;
  token_t q_tok;
  logic   pop;

  hdlc_rx_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .push     (push),
    .push_tok (push_tok)
  );

  hdlc_rx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_tok (push_tok),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_tok    (q_tok),
    .pop      (pop)
  );

  hdlc_rx_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .q_valid        (q_valid),
    .q_tok          (q_tok),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .data_byte      (data_byte),
    .frame_status   (frame_status),
    .frame_addr     (frame_addr),
    .frame_ctrl     (frame_ctrl),
    .payload_len    (payload_len)
  );

endmodule

### sv/hdlc_rx_checker.sv
// ----------------------------------------------------------------------------
// HDLC receiver port checker
// Watches the top-level ports for result formatting and output handshake.
// ----------------------------------------------------------------------------
module hdlc_rx_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_kind,
  input logic [7:0]  data_byte,
  input logic [2:0]  frame_status,
  input logic [7:0]  frame_addr,
  input logic [7:0]  frame_ctrl,
  input logic [10:0] payload_len
);
  import hdlc_rx_pkg::*;

  // Nothing is presented in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds until it is transferred.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
      $stable(data_byte) && $stable(frame_status) && $stable(payload_len))
    else $error("stalled result changed");

  // Data results carry no frame information.
  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_DATA |->
      frame_status == STAT_SUP_OK && frame_addr == '0 &&
      frame_ctrl == '0 && payload_len == '0)
    else $error("data result with frame fields set");

  // Only information and payload-error status carries a length.
  a_len_only_info: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_STATUS && payload_len != '0 |->
      frame_status == STAT_INFO_OK || frame_status == STAT_PAY_ERR)
    else $error("payload length on a status without payload");

endmodule

bind hdlc_frame_receiver hdlc_rx_checker u_hdlc_rx_checker (.*);

### test/hdlc_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HDLC frame receiver checker
// Watches the line byte, result and payload limit ports of the receiver. It
// keeps its own deframing state, predicts the data and status results of every
// accepted line byte and compares each result transfer, field by field, with
// the oldest prediction.
// ----------------------------------------------------------------------------
module hdlc_frame_checker #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_write_en,
  input  logic [10:0] cfg_write_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_kind,
  input  logic [7:0]  data_byte,
  input  logic [2:0]  frame_status,
  input  logic [7:0]  frame_addr,
  input  logic [7:0]  frame_ctrl,
  input  logic [10:0] payload_len,
  output int          mismatches,
  output int          outstanding
);
  import hdlc_rx_pkg::*;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic [2:0]        status;
    logic [BYTE_W-1:0] addr;
    logic [BYTE_W-1:0] ctrl;
    logic [LEN_W-1:0]  len;
  } rx_result_t;

  rx_result_t pending_results [$];

  logic [LEN_W-1:0]  payload_limit;
  logic              in_frame;
  logic              esc_pending;
  logic [LEN_W-1:0]  frame_index;
  logic [BYTE_W-1:0] hdr_addr;
  logic [BYTE_W-1:0] hdr_ctrl;
  logic              hdr_ok;
  logic [BYTE_W-1:0] held_byte;
  logic [BYTE_W-1:0] payload_xor;
  logic              overflow;

  function automatic void clear_frame();
    esc_pending = 1'b0;
    frame_index = '0;
    hdr_addr    = '0;
    hdr_ctrl    = '0;
    hdr_ok      = 1'b0;
    held_byte   = '0;
    payload_xor = '0;
    overflow    = 1'b0;
  endfunction

  // A limit of zero behaves as one; anything above the build size is clipped.
  function automatic logic [LEN_W-1:0] effective_limit();
    if (payload_limit == '0) begin
      return LEN_W'(1);
    end
    if (payload_limit > MAX_PAYLOAD) begin
      return LEN_W'(MAX_PAYLOAD);
    end
    return payload_limit;
  endfunction

  function automatic void decode_line_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] d;
    logic [2:0]        st;
    logic [LEN_W-1:0]  len;
    if (!in_frame) begin
      if (b == FLAG_BYTE) begin
        in_frame = 1'b1;
        clear_frame();
      end
    end else if (b == FLAG_BYTE) begin
      if (frame_index != '0 || esc_pending) begin
        len = '0;
        if (esc_pending || overflow || frame_index < 3 || frame_index == 4) begin
          st = STAT_FMT_ERR;
        end else if (!hdr_ok) begin
          st = STAT_HDR_ERR;
        end else if (frame_index == 3) begin
          st = STAT_SUP_OK;
        end else begin
          len = frame_index - 11'd4;
          st  = (payload_xor == '0) ? STAT_INFO_OK : STAT_PAY_ERR;
        end
        pending_results.push_back('{KIND_STATUS, 8'h00, st, hdr_addr, hdr_ctrl, len});
        clear_frame();
      end
    end else if (!esc_pending && b == ESC_BYTE) begin
      esc_pending = 1'b1;
    end else begin
      d = esc_pending ? (b ^ ESC_XOR) : b;
      esc_pending = 1'b0;
      if (frame_index == 0) begin
        hdr_addr = d;
        frame_index = frame_index + 1'b1;
      end else if (frame_index == 1) begin
        hdr_ctrl = d;
        frame_index = frame_index + 1'b1;
      end else if (frame_index == 2) begin
        hdr_ok = (d == (hdr_addr ^ hdr_ctrl));
        frame_index = frame_index + 1'b1;
      end else begin
        payload_xor = payload_xor ^ d;
        // The held byte is released only once a later byte proves it is not BCC2.
        if (frame_index >= 4) begin
          if (frame_index - 11'd3 > effective_limit()) begin
            overflow = 1'b1;
          end
          if (hdr_ok && !overflow) begin
            pending_results.push_back('{KIND_DATA, held_byte, STAT_SUP_OK, 8'h00, 8'h00, 11'd0});
          end
        end
        held_byte = d;
        if (frame_index < INDEX_MAX) begin
          frame_index = frame_index + 1'b1;
        end
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [10:0] want,
                                      input logic [10:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    rx_result_t want;
    if (rst) begin
      payload_limit = LEN_W'(MAX_PAYLOAD);
      in_frame = 1'b0;
      clear_frame();
      pending_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_write_en) begin
        payload_limit = cfg_write_data;
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no result predicted");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("out_kind", 11'(want.kind), 11'(out_kind));
          check_field("data_byte", 11'(want.data), 11'(data_byte));
          check_field("frame_status", 11'(want.status), 11'(frame_status));
          check_field("frame_addr", 11'(want.addr), 11'(frame_addr));
          check_field("frame_ctrl", 11'(want.ctrl), 11'(frame_ctrl));
          check_field("payload_len", want.len, payload_len);
        end
      end
      if (in_valid && !in_stall) begin
        decode_line_byte(rx_byte);
      end
    end
    outstanding = pending_results.size();
  end

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HDLC frame receiver testbench
// Drives line bytes into the receiver: a short directed sequence, then mostly
// well-formed stuffed frames with random content mixed with line noise and cut
// frames, across several payload limits and idle patterns on both channels.
// The checker beside the receiver predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import hdlc_rx_pkg::*;

  localparam int MAX_PAYLOAD = 1024;
  localparam int QUIET_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int PHASES = 8;

  localparam logic [10:0] LIMIT_STEPS [PHASES] = '{
    11'd1024, 11'd1, 11'd0, 11'd6, 11'd2047, 11'd2, 11'd1, 11'd1024
  };

  // Hunting bytes, repeated flags, an escaped header-only frame, a short frame,
  // an escape right before a flag, a four-byte frame and a good information frame.
  localparam logic [7:0] DIRECTED_BYTES [26] = '{
    8'h00, 8'hFF, 8'h7E, 8'h7E,
    8'h7D, 8'h5E, 8'h03, 8'h7D, 8'h5D, 8'h7E,
    8'h01, 8'h7E,
    8'h7D, 8'h7E,
    8'h01, 8'h02, 8'h03, 8'hFF, 8'h7E,
    8'hFF, 8'h00, 8'hFF, 8'hAA, 8'h55, 8'hFF, 8'h7E
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        cfg_write_en = 1'b0;
  logic [10:0] cfg_write_data = 11'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [7:0]  data_byte;
  logic [2:0]  frame_status;
  logic [7:0]  frame_addr;
  logic [7:0]  frame_ctrl;
  logic [10:0] payload_len;

  int mismatches;
  int outstanding;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold_left = 0;
  int items_sent = 0;
  int cur_limit = MAX_PAYLOAD;
  int quiet_cycles = 0;
  bit last_flag = 1'b0;

  hdlc_frame_receiver #(.MAX_PAYLOAD(MAX_PAYLOAD)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .data_byte(data_byte), .frame_status(frame_status),
    .frame_addr(frame_addr), .frame_ctrl(frame_ctrl), .payload_len(payload_len)
  );

  hdlc_frame_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .data_byte(data_byte), .frame_status(frame_status),
    .frame_addr(frame_addr), .frame_ctrl(frame_ctrl), .payload_len(payload_len),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver side: a long hold requested by the stimulus wins over random stalls.
  always @(negedge clk) begin
    if (recv_hold_left > 0) begin
      out_stall <= 1'b1;
      recv_hold_left = recv_hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
    items_sent++;
    last_flag = (b == FLAG_BYTE);
  endtask

  // Special bytes must be escaped; a few ordinary ones are escaped as well.
  task automatic send_stuffed(input logic [7:0] d);
    if (d == FLAG_BYTE || d == ESC_BYTE || $urandom_range(0, 19) == 0) begin
      send_byte(ESC_BYTE);
      send_byte(d ^ ESC_XOR);
    end else begin
      send_byte(d);
    end
  endtask

  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 9))
      0: return FLAG_BYTE;
      1: return ESC_BYTE;
      2: return FLAG_BYTE ^ ESC_XOR;
      default: return 8'($urandom);
    endcase
  endfunction

  // A payload length below zero sends a header-only frame.
  task automatic send_hdlc_frame(input int plen, input bit hdr_bad, input bit sum_bad);
    logic [7:0] a, c, bcc, sum, d;
    a = rand_data();
    c = rand_data();
    bcc = a ^ c;
    if (hdr_bad) begin
      bcc = bcc ^ (8'h01 << $urandom_range(0, 7));
    end
    if (!last_flag || $urandom_range(0, 3) == 0) begin
      send_byte(FLAG_BYTE);
    end
    send_stuffed(a);
    send_stuffed(c);
    send_stuffed(bcc);
    if (plen >= 0) begin
      sum = 8'h00;
      repeat (plen) begin
        d = rand_data();
        sum = sum ^ d;
        send_stuffed(d);
      end
      if (sum_bad) begin
        sum = sum ^ (8'h01 << $urandom_range(0, 7));
      end
      send_stuffed(sum);
    end
    send_byte(FLAG_BYTE);
  endtask

  task automatic send_line_noise(input int n);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1: send_byte(FLAG_BYTE);
        2, 3: send_byte(ESC_BYTE);
        default: send_byte(8'($urandom));
      endcase
    end
  endtask

  // Short frames, four-byte frames, empty frames and an escape before the flag.
  task automatic send_cut_frame();
    int n;
    n = $urandom_range(0, 5);
    send_byte(FLAG_BYTE);
    repeat (n) begin
      send_stuffed(rand_data());
    end
    if ($urandom_range(0, 1) == 1) begin
      send_byte(ESC_BYTE);
    end
    send_byte(FLAG_BYTE);
  endtask

  task automatic random_item();
    int pick;
    int plen;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      if ($urandom_range(0, 9) == 0) begin
        plen = -1;
      end else if ($urandom_range(0, 5) == 0) begin
        plen = $urandom_range(0, (cur_limit < 40) ? cur_limit + 2 : 40);
      end else begin
        plen = $urandom_range(1, (cur_limit < 8) ? cur_limit : 8);
      end
      send_hdlc_frame(plen, $urandom_range(0, 11) == 0, $urandom_range(0, 9) == 0);
    end else if (pick < 85) begin
      send_line_noise($urandom_range(1, 8));
    end else begin
      send_cut_frame();
    end
  endtask

  // Frames that end in no result may still sit in the token queue, so the
  // sender waits on past the last predicted result.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (outstanding != 0) begin
      @(negedge clk);
    end
    repeat (16) @(negedge clk);
  endtask

  task automatic write_payload_limit(input logic [10:0] value);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    if (value == 11'd0) begin
      cur_limit = 1;
    end else if (value > MAX_PAYLOAD) begin
      cur_limit = MAX_PAYLOAD;
    end else begin
      cur_limit = int'(value);
    end
  endtask

  initial begin
    logic [10:0] limit_value;
    int stop_at;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct = (ph < 3) ? 10 : (ph < 6) ? 81 : 0;
      recv_idle_pct = (ph < 3) ? 81 : (ph < 6) ? 10 : 0;
      if (ph > 0) begin
        wait_for_results();
        limit_value = (ph == 6) ? 11'($urandom_range(1, 40)) : LIMIT_STEPS[ph];
        write_payload_limit(limit_value);
      end
      if (ph == 0) begin
        foreach (DIRECTED_BYTES[i]) begin
          send_byte(DIRECTED_BYTES[i]);
        end
        // Hold the result side while a long frame keeps coming, so the
        // receiver fills up and stalls its input; then let everything drain.
        recv_hold_left = 300;
        send_hdlc_frame(40, 1'b0, 1'b0);
        wait_for_results();
      end
      stop_at = items_sent + ITEMS_PER_PHASE;
      while (items_sent < stop_at) begin
        random_item();
      end
    end
    in_valid <= 1'b0;
    while (outstanding != 0) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/hdlc_rx_pkg.sv
sv/hdlc_rx_front.sv
sv/hdlc_rx_queue.sv
sv/hdlc_rx_back.sv
sv/hdlc_frame_receiver.sv
sv/hdlc_rx_checker.sv
test/hdlc_frame_checker.sv
test/tb.sv
